/* rtl/core/polygon_area_statistics_defines.svh */
// Assertion macros shared by the polygon area statistics RTL.
// Depends on nothing; included by files that carry concurrent assertions.
`ifndef POLYGON_AREA_STATISTICS_DEFINES_SVH
`define POLYGON_AREA_STATISTICS_DEFINES_SVH

// The antecedent implies the consequent in the same cycle.
`define PAS_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("polygon_area_statistics: same-cycle check failed");

// The antecedent implies the consequent in the next cycle.
`define PAS_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("polygon_area_statistics: next-cycle check failed");

`endif

/* rtl/core/pas_pkg.sv */
// Package for the polygon area statistics block: widths, codes and types.
// Used by pas_mac, pas_div and polygon_area_statistics; depends on nothing.
`timescale 1ns / 1ps

package pas_pkg;

    localparam int FIELD_W = 16;
    localparam int COORD_W = 17;
    localparam int PROD_W  = 2 * COORD_W + 2;
    localparam int ACC_W   = 60;
    localparam int SUM_W   = 61;
    localparam int VALUE_W = 62;
    localparam int MODE_W  = 4;
    localparam int TGT_W   = 9;
    localparam int STAT_W  = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic signed [SUM_W-1:0] TWICE_CAP = SUM_W'((64'd1 << 59) - 64'd1);
    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    localparam logic [CFG_IDX_W-1:0] CFG_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TARGET = 2'd1;

    localparam logic [MODE_W-1:0] MODE_SUM_EVEN   = 4'd0;
    localparam logic [MODE_W-1:0] MODE_SUM_ODD    = 4'd1;
    localparam logic [MODE_W-1:0] MODE_MEAN       = 4'd2;
    localparam logic [MODE_W-1:0] MODE_SUM_TARGET = 4'd3;
    localparam logic [MODE_W-1:0] MODE_MAX_AREA   = 4'd4;
    localparam logic [MODE_W-1:0] MODE_MIN_AREA   = 4'd5;
    localparam logic [MODE_W-1:0] MODE_CNT_EVEN   = 4'd6;
    localparam logic [MODE_W-1:0] MODE_CNT_ODD    = 4'd7;
    localparam logic [MODE_W-1:0] MODE_CNT_TARGET = 4'd8;
    localparam logic [MODE_W-1:0] MODE_MAX_VERTS  = 4'd9;
    localparam logic [MODE_W-1:0] MODE_MIN_VERTS  = 4'd10;

    localparam logic [TGT_W-1:0] TARGET_RESET = 9'd3;
    localparam logic [TGT_W-1:0] MIN_TARGET   = 9'd3;

    localparam logic [STAT_W-1:0] ST_OK         = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY      = 2'd1;
    localparam logic [STAT_W-1:0] ST_LOW_TARGET = 2'd2;

    typedef struct packed {
        logic load;
        logic mul;
        logic acc;
        logic clr;
    } t_mac_ctl;

endpackage

/* rtl/core/pas_mac.sv */
// Shared shoelace term unit: operand add/subtract, one multiply, saturating accumulate.
// Depends on pas_pkg; instantiated by polygon_area_statistics.
`timescale 1ns / 1ps

module pas_mac (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  pas_pkg::t_mac_ctl                    i_ctl,
    input  logic signed [pas_pkg::COORD_W-1:0]   i_ax,
    input  logic signed [pas_pkg::COORD_W-1:0]   i_ay,
    input  logic signed [pas_pkg::COORD_W-1:0]   i_bx,
    input  logic signed [pas_pkg::COORD_W-1:0]   i_by,
    output logic        [pas_pkg::VALUE_W-1:0]   o_area
);

    localparam int CW = pas_pkg::COORD_W;
    localparam int AW = pas_pkg::ACC_W;
    localparam int SW = pas_pkg::SUM_W;
    localparam int PW = pas_pkg::PROD_W;

    logic signed [CW:0]   r_ysum;
    logic signed [CW:0]   r_xdiff;
    logic signed [PW-1:0] r_prod;
    logic signed [AW-1:0] r_acc;
    logic signed [AW-1:0] n_acc;
    logic signed [SW-1:0] w_sum;
    logic signed [SW-1:0] w_sat;
    logic        [AW-1:0] w_mag;

    always_comb begin
        w_sum = $signed({{(SW - AW){r_acc[AW-1]}}, r_acc})
              + $signed({{(SW - PW){r_prod[PW-1]}}, r_prod});
        if (w_sum > pas_pkg::TWICE_CAP) begin
            w_sat = pas_pkg::TWICE_CAP;
        end else if (w_sum < -pas_pkg::TWICE_CAP) begin
            w_sat = -pas_pkg::TWICE_CAP;
        end else begin
            w_sat = w_sum;
        end
        n_acc = w_sat[AW-1:0];
        w_mag = r_acc[AW-1] ? AW'(-r_acc) : AW'(r_acc);
        o_area = {w_mag[AW-2:0], 3'b000};
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_ysum  <= $signed({i_ay[CW-1], i_ay}) + $signed({i_by[CW-1], i_by});
            r_xdiff <= $signed({i_bx[CW-1], i_bx}) - $signed({i_ax[CW-1], i_ax});
        end
        if (i_ctl.mul) begin
            r_prod <= r_ysum * r_xdiff;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
        end else if (i_ctl.clr) begin
            r_acc <= '0;
        end else if (i_ctl.acc) begin
            r_acc <= n_acc;
        end
    end

endmodule

/* rtl/core/pas_div.sv */
// Restoring serial divider, one quotient bit per cycle, for the mean area.
// Depends on pas_pkg; instantiated by polygon_area_statistics.
`timescale 1ns / 1ps

module pas_div #(
    parameter int DVS_W = 17
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [pas_pkg::VALUE_W-1:0]   i_dividend,
    input  logic [DVS_W-1:0]              i_divisor,
    output logic                          o_busy,
    output logic                          o_done,
    output logic [pas_pkg::VALUE_W-1:0]   o_quotient
);

    localparam int VW    = pas_pkg::VALUE_W;
    localparam int CNT_W = $clog2(VW);

    logic [VW-1:0]    r_quo;
    logic [DVS_W-1:0] r_rem;
    logic [DVS_W-1:0] r_dvs;
    logic [CNT_W-1:0] r_cnt;
    logic             r_busy;
    logic             r_done;
    logic [DVS_W:0]   w_trial;
    logic             w_fit;

    always_comb begin
        w_trial = {r_rem, r_quo[VW-1]};
        w_fit   = (w_trial >= {1'b0, r_dvs});
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_quo <= {r_quo[VW-2:0], w_fit};
            r_rem <= w_fit ? DVS_W'(w_trial - {1'b0, r_dvs}) : w_trial[DVS_W-1:0];
            r_cnt <= r_cnt + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_cnt == CNT_W'(VW - 1))) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    assign o_busy     = r_busy;
    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

/* rtl/core/polygon_area_statistics.sv */
// Top level of the polygon area statistics block: sequencer, set statistics, ports.
// Depends on pas_pkg, pas_mac, pas_div and polygon_area_statistics_defines.svh.
`timescale 1ns / 1ps
`include "polygon_area_statistics_defines.svh"

// Vertices arrive one request at a time and the block stalls its input while a
// request is in work. An ordinary vertex goes through accept, multiply and
// accumulate steps in the one shared shoelace multiplier; the first vertex of a
// polygon is only accepted, unless it alone closes the polygon. The vertex that
// closes a longer polygon also sends the closing term through the same multiplier
// before the area is formed and the statistic updated. A vertex that closes the
// set then passes a prepare step and an emit step, with a divide step between
// them in mean mode, where the serial divider produces one quotient bit a cycle.
// The result waits in an output register, so input can resume before it is taken.
module polygon_area_statistics #(
    parameter int MAX_VERTICES = 256,
    parameter int MAX_POLYGONS = 65536,
    parameter int COORD_BITS   = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  logic signed [pas_pkg::FIELD_W-1:0] i_vertex_x,
    input  logic signed [pas_pkg::FIELD_W-1:0] i_vertex_y,
    input  logic                            i_last_vertex,
    input  logic                            i_last_polygon,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output logic [pas_pkg::VALUE_W-1:0]     o_value,
    output logic                            o_is_area,
    output logic [pas_pkg::STAT_W-1:0]      o_status,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [pas_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [pas_pkg::TGT_W-1:0]       i_cfg_data
);

    localparam int VW    = $clog2(MAX_VERTICES + 1);
    localparam int PW    = $clog2(MAX_POLYGONS + 1);
    localparam int TW    = pas_pkg::TGT_W;
    localparam int CMP_W = (VW > TW) ? VW : TW;
    localparam int CW    = pas_pkg::COORD_W;
    localparam int VALW  = pas_pkg::VALUE_W;
    localparam int SH    = (COORD_BITS >= CW) ? 0 : CW - COORD_BITS;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_ACC  = 3'd2;
    localparam logic [2:0] S_AREA = 3'd3;
    localparam logic [2:0] S_UPD  = 3'd4;
    localparam logic [2:0] S_PREP = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_EMIT = 3'd7;

    logic [2:0]               r_state;
    logic [2:0]               n_state;
    logic [pas_pkg::MODE_W-1:0] r_mode;
    logic [TW-1:0]            r_target;
    logic signed [CW-1:0]     r_cur_x;
    logic signed [CW-1:0]     r_cur_y;
    logic signed [CW-1:0]     r_first_x;
    logic signed [CW-1:0]     r_first_y;
    logic signed [CW-1:0]     r_prev_x;
    logic signed [CW-1:0]     r_prev_y;
    logic                     r_lv;
    logic                     r_lp;
    logic                     r_closing;
    logic [VW-1:0]            r_vcnt;
    logic [VALW-1:0]          r_area;
    logic [VALW-1:0]          r_total;
    logic [VALW-1:0]          n_total;
    logic [VALW-1:0]          r_ext;
    logic [VALW-1:0]          n_ext;
    logic                     r_ext_valid;
    logic                     n_ext_valid;
    logic [PW-1:0]            r_polys;
    logic                     r_out_valid;
    logic [VALW-1:0]          r_out_value;
    logic                     r_out_is_area;
    logic [pas_pkg::STAT_W-1:0] r_out_status;

    logic signed [CW-1:0]     w_px;
    logic signed [CW-1:0]     w_py;
    logic signed [CW-1:0]     w_ax;
    logic signed [CW-1:0]     w_ay;
    logic signed [CW-1:0]     w_bx;
    logic signed [CW-1:0]     w_by;
    logic                     w_accept;
    logic                     w_out_free;
    logic                     w_emit;
    logic                     w_div_start;
    logic                     w_div_busy;
    logic                     w_div_done;
    logic [VALW-1:0]          w_quotient;
    logic [VALW-1:0]          w_area;
    pas_pkg::t_mac_ctl        w_ctl;

    logic                     w_even;
    logic                     w_hit;
    logic                     w_add_en;
    logic [VALW-1:0]          w_addend;
    logic [VALW:0]            w_add;
    logic                     w_ext_en;
    logic                     w_want_max;
    logic [VALW-1:0]          w_ext_in;
    logic                     w_take;
    logic                     w_low_target;
    logic [VALW-1:0]          w_value;
    logic                     w_is_area;
    logic [pas_pkg::STAT_W-1:0] w_status;
    logic                     w_poly_gap;
    logic                     w_set_clear;

    always_comb begin
        w_px = ($signed({1'b0, i_vertex_x}) <<< SH) >>> SH;
        w_py = ($signed({1'b0, i_vertex_y}) <<< SH) >>> SH;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_emit      = (r_state == S_EMIT) && w_out_free;

    always_comb begin
        n_state     = r_state;
        w_ctl       = '0;
        w_div_start = 1'b0;
        if (r_state == S_IDLE) begin
            if (r_vcnt == '0) begin
                w_ax = w_px;
                w_ay = w_py;
            end else begin
                w_ax = r_prev_x;
                w_ay = r_prev_y;
            end
            w_bx = w_px;
            w_by = w_py;
        end else begin
            w_ax = r_cur_x;
            w_ay = r_cur_y;
            w_bx = r_first_x;
            w_by = r_first_y;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if ((r_vcnt != '0) || i_last_vertex) begin
                        w_ctl.load = 1'b1;
                        n_state    = S_MUL;
                    end
                end
            end
            S_MUL: begin
                w_ctl.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                w_ctl.acc = 1'b1;
                if (r_closing) begin
                    n_state = S_AREA;
                end else if (r_lv) begin
                    w_ctl.load = 1'b1;
                    n_state    = S_MUL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_AREA: begin
                w_ctl.clr = 1'b1;
                n_state   = S_UPD;
            end
            S_UPD: begin
                n_state = r_lp ? S_PREP : S_IDLE;
            end
            S_PREP: begin
                if ((r_mode == pas_pkg::MODE_MEAN) && (r_polys != '0)) begin
                    w_div_start = 1'b1;
                    n_state     = S_DIV;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        w_even     = ~r_vcnt[0];
        w_hit      = (CMP_W'(r_vcnt) == CMP_W'(r_target));
        w_add_en   = 1'b0;
        w_addend   = r_area;
        w_ext_en   = 1'b0;
        w_want_max = 1'b0;
        w_ext_in   = r_area;
        case (r_mode)
            pas_pkg::MODE_SUM_EVEN:   w_add_en = w_even;
            pas_pkg::MODE_SUM_ODD:    w_add_en = !w_even;
            pas_pkg::MODE_MEAN:       w_add_en = 1'b1;
            pas_pkg::MODE_SUM_TARGET: w_add_en = w_hit;
            pas_pkg::MODE_MAX_AREA: begin
                w_ext_en   = 1'b1;
                w_want_max = 1'b1;
            end
            pas_pkg::MODE_MIN_AREA:   w_ext_en = 1'b1;
            pas_pkg::MODE_CNT_EVEN: begin
                w_add_en = w_even;
                w_addend = VALW'(1);
            end
            pas_pkg::MODE_CNT_ODD: begin
                w_add_en = !w_even;
                w_addend = VALW'(1);
            end
            pas_pkg::MODE_CNT_TARGET: begin
                w_add_en = w_hit;
                w_addend = VALW'(1);
            end
            pas_pkg::MODE_MAX_VERTS: begin
                w_ext_en   = 1'b1;
                w_want_max = 1'b1;
                w_ext_in   = VALW'(r_vcnt);
            end
            pas_pkg::MODE_MIN_VERTS: begin
                w_ext_en = 1'b1;
                w_ext_in = VALW'(r_vcnt);
            end
            default: begin
                w_add_en = 1'b0;
            end
        endcase
        w_add  = {1'b0, r_total} + {1'b0, w_addend};
        w_take = !r_ext_valid || (w_want_max ? (w_ext_in > r_ext) : (w_ext_in < r_ext));

        n_total     = r_total;
        n_ext       = r_ext;
        n_ext_valid = r_ext_valid;
        if (w_emit) begin
            n_total     = '0;
            n_ext       = '0;
            n_ext_valid = 1'b0;
        end else if (r_state == S_UPD) begin
            if (w_add_en) begin
                n_total = w_add[VALW] ? pas_pkg::VALUE_MAX : w_add[VALW-1:0];
            end
            if (w_ext_en) begin
                n_ext_valid = 1'b1;
                if (w_take) begin
                    n_ext = w_ext_in;
                end
            end
        end
    end

    always_comb begin
        w_low_target = (r_target < pas_pkg::MIN_TARGET);
        w_value      = '0;
        w_is_area    = 1'b0;
        w_status     = pas_pkg::ST_OK;
        case (r_mode)
            pas_pkg::MODE_SUM_EVEN, pas_pkg::MODE_SUM_ODD: begin
                w_is_area = 1'b1;
                w_value   = r_total;
            end
            pas_pkg::MODE_MEAN: begin
                w_is_area = 1'b1;
                if (r_polys == '0) begin
                    w_status = pas_pkg::ST_EMPTY;
                end else begin
                    w_value = w_quotient;
                end
            end
            pas_pkg::MODE_SUM_TARGET: begin
                w_is_area = 1'b1;
                if (w_low_target) begin
                    w_status = pas_pkg::ST_LOW_TARGET;
                end else begin
                    w_value = r_total;
                end
            end
            pas_pkg::MODE_MAX_AREA, pas_pkg::MODE_MIN_AREA: begin
                w_is_area = 1'b1;
                if (!r_ext_valid) begin
                    w_status = pas_pkg::ST_EMPTY;
                end else begin
                    w_value = r_ext;
                end
            end
            pas_pkg::MODE_CNT_EVEN, pas_pkg::MODE_CNT_ODD: begin
                w_value = r_total;
            end
            pas_pkg::MODE_CNT_TARGET: begin
                if (w_low_target) begin
                    w_status = pas_pkg::ST_LOW_TARGET;
                end else begin
                    w_value = r_total;
                end
            end
            pas_pkg::MODE_MAX_VERTS, pas_pkg::MODE_MIN_VERTS: begin
                if (!r_ext_valid) begin
                    w_status = pas_pkg::ST_EMPTY;
                end else begin
                    w_value = r_ext;
                end
            end
            default: begin
                w_value = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cur_x  <= w_px;
            r_cur_y  <= w_py;
            r_prev_x <= w_px;
            r_prev_y <= w_py;
            r_lv     <= i_last_vertex;
            r_lp     <= i_last_polygon;
            if (r_vcnt == '0) begin
                r_first_x <= w_px;
                r_first_y <= w_py;
            end
        end
        if (r_state == S_AREA) begin
            r_area <= w_area;
        end
        if (w_emit) begin
            r_out_value   <= w_value;
            r_out_is_area <= w_is_area;
            r_out_status  <= w_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= pas_pkg::MODE_SUM_EVEN;
            r_target    <= pas_pkg::TARGET_RESET;
            r_closing   <= 1'b0;
            r_vcnt      <= '0;
            r_total     <= '0;
            r_ext       <= '0;
            r_ext_valid <= 1'b0;
            r_polys     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_total     <= n_total;
            r_ext       <= n_ext;
            r_ext_valid <= n_ext_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == pas_pkg::CFG_MODE) begin
                    r_mode <= i_cfg_data[pas_pkg::MODE_W-1:0];
                end else if (i_cfg_index == pas_pkg::CFG_TARGET) begin
                    r_target <= i_cfg_data;
                end
            end
            if (w_accept) begin
                r_closing <= (r_vcnt == '0);
                if (r_vcnt < VW'(MAX_VERTICES)) begin
                    r_vcnt <= r_vcnt + 1'b1;
                end
            end else if ((r_state == S_ACC) && !r_closing && r_lv) begin
                r_closing <= 1'b1;
            end
            if (r_state == S_UPD) begin
                r_vcnt <= '0;
                if (r_polys < PW'(MAX_POLYGONS)) begin
                    r_polys <= r_polys + 1'b1;
                end
            end else if (w_emit) begin
                r_polys <= '0;
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    pas_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_ax    (w_ax),
        .i_ay    (w_ay),
        .i_bx    (w_bx),
        .i_by    (w_by),
        .o_area  (w_area)
    );

    pas_div #(
        .DVS_W (PW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (r_total),
        .i_divisor  (r_polys),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    assign o_out_valid = r_out_valid;
    assign o_value     = r_out_value;
    assign o_is_area   = r_out_is_area;
    assign o_status    = r_out_status;

    assign w_poly_gap  = (r_state == S_IDLE) && (r_vcnt == '0);
    assign w_set_clear = (r_polys == '0) && !r_ext_valid && (r_total == '0);

    // The divider only runs while the sequencer waits for it.
    `PAS_ASSERT_IMPL(a_div_in_div_state, i_clk, i_rst_n, w_div_busy, r_state == S_DIV)
    // Between polygons the accumulator must hold no leftover area.
    `PAS_ASSERT_IMPL(a_acc_clear_idle, i_clk, i_rst_n, w_poly_gap, w_area == '0)
    // A new result always leaves the set statistics cleared.
    `PAS_ASSERT_IMPL(a_set_cleared, i_clk, i_rst_n, $rose(r_out_valid), w_set_clear)
    // Closing a set always leads to the prepare step.
    `PAS_ASSERT_NEXT(a_upd_to_prep, i_clk, i_rst_n, (r_state == S_UPD) && r_lp, r_state == S_PREP)

endmodule
